>>> rtl/pair_table_with_slot_reuse_top_macros.svh
// Assertion macros shared by the pair table checker.
`ifndef PAIR_TABLE_WITH_SLOT_REUSE_TOP_MACROS_SVH
`define PAIR_TABLE_WITH_SLOT_REUSE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ptsr_pkg.sv
// Shared types and constants of the pair table with slot reuse.
package ptsr_pkg;

    // Id and time fields are all this wide.
    localparam int ID_W = 32;

    // Input item: op, first id, second id, time, padded to whole bytes.
    localparam int IN_W       = 2 + 3 * ID_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    // Pair memory word: {valid, second id, first id}.
    localparam int PAIR_W = 2 * ID_W + 1;

    // Operation codes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_PAIR   = 2'd1;
    localparam logic [1:0] OP_FIRST  = 2'd2;
    localparam logic [1:0] OP_SECOND = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_RESERVED = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_NOMATCH  = 2'd3;

    // Control sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

>>> rtl/pair_table_with_slot_reuse_top.sv
// Pair table with a free-slot stack: adds, pair removal and removal by either id.
//
// One item is handled at a time. An add that appends a new slot writes it as the item is
// accepted, an add that reuses a freed slot first reads the top of the free stack, and a
// rejected item goes straight to its result. A removal scans the slots below the used
// count through the single read port of the pair memory, one slot per cycle, and a pair
// removal stops at its first match. No clearing pass is needed after reset. The result
// waits in an output register; the next item is taken once the sequencer is back to idle.
module pair_table_with_slot_reuse_top #(
    parameter int TABLE_DEPTH = 1024,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_W = 2 + 2 * CNT_W + ptsr_pkg::ID_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op, first_id, second_id, now_time (lowest bits first)
    input  logic [ptsr_pkg::IN_TDATA_W-1:0] s_tdata,
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, removed_count, live_count, modified_time (lowest bits first)
    output logic [OUT_TDATA_W-1:0]          m_tdata,
    // Reserved id register write.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptsr_pkg::ID_W-1:0]       cfg_data
);

    import ptsr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    // Input fields.
    logic [1:0]      in_op;
    logic [ID_W-1:0] in_fid;
    logic [ID_W-1:0] in_sid;
    logic [ID_W-1:0] in_now;

    // Control registers.
    state_t           state_reg, state_next;
    logic [ID_W-1:0]  reserved_reg, reserved_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [ID_W-1:0]  last_reg, last_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [1:0]             op_reg, op_next;
    logic [ID_W-1:0]        fid_reg, fid_next;
    logic [ID_W-1:0]        sid_reg, sid_next;
    logic [ID_W-1:0]        now_reg, now_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    logic [1:0]             status_reg, status_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Memory ports.
    logic              pair_we;
    logic [AW-1:0]     pair_waddr;
    logic [PAIR_W-1:0] pair_wdata;
    logic [AW-1:0]     pair_raddr;
    logic [PAIR_W-1:0] pair_rdata;
    logic              stack_we;
    logic [AW-1:0]     stack_waddr;
    logic [AW-1:0]     stack_wdata;
    logic [AW-1:0]     stack_raddr;
    logic [AW-1:0]     stack_rdata;

    // Scan helpers.
    logic             in_fire;
    logic [CNT_W-1:0] free_dec;
    logic [CNT_W-1:0] live;
    logic             match;
    logic             stop_pair;
    logic             issue;
    logic             rd_valid;
    logic [ID_W-1:0]  rd_first;
    logic [ID_W-1:0]  rd_second;

    assign in_op  = s_tdata[1:0];
    assign in_fid = s_tdata[2 +: ID_W];
    assign in_sid = s_tdata[2 + ID_W +: ID_W];
    assign in_now = s_tdata[2 + 2 * ID_W +: ID_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign free_dec  = free_reg - CNT_W'(1);
    assign live      = used_reg - free_reg;
    assign rd_first  = pair_rdata[ID_W-1:0];
    assign rd_second = pair_rdata[2*ID_W-1:ID_W];
    assign rd_valid  = pair_rdata[PAIR_W-1];

    // Pair memory: first id, second id and a live flag per slot.
    ptsr_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    // Free stack: indexes of cleared slots.
    ptsr_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Match test on the slot whose read data arrives this cycle.
    always_comb
    begin
        match = 1'b0;
        if (pend_reg)
        begin
            case (op_reg)
                OP_PAIR:  match = rd_valid && (rd_first == fid_reg) && (rd_second == sid_reg);
                OP_FIRST: match = rd_valid && (rd_first == fid_reg);
                default:  match = rd_valid && (rd_second == sid_reg);
            endcase
        end
    end

    assign stop_pair = match && (op_reg == OP_PAIR);
    assign issue     = !stop_pair && (idx_reg < used_reg);

    // Sequencer and memory access control.
    always_comb
    begin
        state_next     = state_reg;
        reserved_next  = reserved_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        fid_next       = fid_reg;
        sid_next       = sid_reg;
        now_next       = now_reg;
        pend_idx_next  = pend_idx_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;

        pair_we     = 1'b0;
        pair_waddr  = pend_idx_reg;
        pair_wdata  = {1'b0, reserved_reg, reserved_reg};
        pair_raddr  = idx_reg[AW-1:0];
        stack_we    = 1'b0;
        stack_waddr = free_reg[AW-1:0];
        stack_wdata = pend_idx_reg;
        stack_raddr = free_dec[AW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            reserved_next = cfg_data;
        end

        // The result register empties when the item is taken.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next      = in_op;
                    fid_next     = in_fid;
                    sid_next     = in_sid;
                    now_next     = in_now;
                    removed_next = '0;
                    status_next  = STATUS_DONE;
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    state_next   = ST_FIN;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (in_fid == reserved_reg || in_sid == reserved_reg)
                            begin
                                status_next = STATUS_RESERVED;
                            end
                            else if (free_reg != '0)
                            begin
                                // Pop a freed slot; its index arrives next cycle.
                                free_next  = free_dec;
                                state_next = ST_POP;
                            end
                            else if (used_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                pair_we    = 1'b1;
                                pair_waddr = used_reg[AW-1:0];
                                pair_wdata = {1'b1, in_sid, in_fid};
                                used_next  = used_reg + CNT_W'(1);
                                last_next  = in_now;
                            end
                        end
                        OP_PAIR:
                        begin
                            if (in_fid == reserved_reg || in_sid == reserved_reg)
                            begin
                                status_next = STATUS_RESERVED;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_FIRST:
                        begin
                            if (in_fid == reserved_reg)
                            begin
                                status_next = STATUS_RESERVED;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            if (in_sid == reserved_reg)
                            begin
                                status_next = STATUS_RESERVED;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                // Reuse the slot from the top of the free stack.
                pair_we    = 1'b1;
                pair_waddr = stack_rdata;
                pair_wdata = {1'b1, sid_reg, fid_reg};
                last_next  = now_reg;
                state_next = ST_FIN;
            end

            ST_SCAN:
            begin
                // Clear a matching slot and push its index.
                if (match)
                begin
                    pair_we      = 1'b1;
                    removed_next = removed_reg + CNT_W'(1);
                    if (free_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        stack_we  = 1'b1;
                        free_next = free_reg + CNT_W'(1);
                    end
                end

                // Issue the read of the next slot.
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Scan ends on the first pair match or after the last used slot.
                if (stop_pair || (!issue && !pend_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = ST_FIN;
                    if (removed_next != '0)
                    begin
                        last_next = now_reg;
                    end
                    else
                    begin
                        status_next = STATUS_NOMATCH;
                    end
                end
            end

            ST_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({last_reg, live, removed_reg, status_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            reserved_reg  <= '0;
            used_reg      <= '0;
            free_reg      <= '0;
            last_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reserved_reg  <= reserved_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload and result.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        fid_reg      <= fid_next;
        sid_reg      <= sid_next;
        now_reg      <= now_next;
        pend_idx_reg <= pend_idx_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> rtl/ptsr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ptsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ptsr_checker.sv
// Port-level checker for the pair table, bound to the top level.
module ptsr_checker #(
    parameter int TABLE_DEPTH = 1024,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_W = 2 + 2 * CNT_W + ptsr_pkg::ID_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    import ptsr_pkg::*;

`include "pair_table_with_slot_reuse_top_macros.svh"

    logic [1:0]       res_status;
    logic [CNT_W-1:0] res_removed;
    logic [CNT_W-1:0] res_live;

    assign res_status  = m_tdata[1:0];
    assign res_removed = m_tdata[2 +: CNT_W];
    assign res_live    = m_tdata[2 + CNT_W +: CNT_W];

    // A waiting result holds until taken.
    `PTSR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // One item at a time: intake closes right after an item is accepted.
    `PTSR_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    // The live count never exceeds the table depth.
    `PTSR_ASSERT_NOW(a_live_bound, clk, rst_n, m_tvalid, res_live <= CNT_W'(TABLE_DEPTH), "live count beyond table depth")

    // Only a successful item clears slots.
    `PTSR_ASSERT_NOW(a_fail_clean, clk, rst_n, m_tvalid && res_status != STATUS_DONE, res_removed == '0, "failed item reports cleared slots")

endmodule

bind pair_table_with_slot_reuse_top ptsr_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ptsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/link_table_check_pkg.sv
// Expected-result tracking for the pair table: a mirror of the table state and a reply queue.
package link_table_check_pkg;

    import ptsr_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int CNT_W = 11;

    // One request as it travels on s_tdata, op in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0] now_time;
        logic [ID_W-1:0] second_id;
        logic [ID_W-1:0] first_id;
        logic [1:0]      op;
    } link_request_t;

    // One reply as it travels on m_tdata, status in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]  modified_time;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] removed_count;
        logic [1:0]       status;
    } link_reply_t;

    // Mirrors the link table and the free-slot stack, and queues the reply that each request earns.
    class link_table_tracker;
        logic [ID_W-1:0] reserved;
        logic [ID_W-1:0] first_ids [TABLE_DEPTH];
        logic [ID_W-1:0] second_ids [TABLE_DEPTH];
        logic [ID_W-1:0] stamps [TABLE_DEPTH];
        int unsigned     free_slots [TABLE_DEPTH];
        bit              occupied [TABLE_DEPTH];
        int unsigned     used_count;
        int unsigned     free_count;
        logic [ID_W-1:0] last_change;
        link_reply_t     awaited_replies [$];
        int              errors;

        function new();
            reserved = '0;
            used_count = 0;
            free_count = 0;
            last_change = '0;
            errors = 0;
            foreach (occupied[i])
            begin
                occupied[i] = 1'b0;
            end
        endfunction

        // Freed slots take the reserved id and go on the stack in the order they are cleared.
        function void release_slot(int unsigned slot);
            first_ids[slot] = reserved;
            second_ids[slot] = reserved;
            occupied[slot] = 1'b0;
            if (free_count < TABLE_DEPTH)
            begin
                free_slots[free_count] = slot;
                free_count++;
            end
        endfunction

        function void store_link(int unsigned slot, link_request_t req);
            first_ids[slot] = req.first_id;
            second_ids[slot] = req.second_id;
            stamps[slot] = req.now_time;
            occupied[slot] = 1'b1;
            last_change = req.now_time;
        endfunction

        // Applies one accepted request to the mirror and queues its reply.
        function void apply_request(link_request_t req);
            link_reply_t     reply;
            logic [ID_W-1:0] key;
            logic [ID_W-1:0] held;
            int unsigned     removed;
            int unsigned     scan_end;
            removed = 0;
            scan_end = used_count;
            reply.status = STATUS_DONE;
            case (req.op)
                OP_ADD:
                begin
                    if (req.first_id == reserved || req.second_id == reserved)
                        reply.status = STATUS_RESERVED;
                    else if (free_count > 0)
                    begin
                        free_count--;
                        store_link(free_slots[free_count], req);
                    end
                    else if (used_count >= TABLE_DEPTH)
                        reply.status = STATUS_FULL;
                    else
                    begin
                        store_link(used_count, req);
                        used_count++;
                    end
                end
                OP_PAIR:
                begin
                    if (req.first_id == reserved || req.second_id == reserved)
                        reply.status = STATUS_RESERVED;
                    else
                    begin
                        // Only the lowest matching slot is cleared.
                        reply.status = STATUS_NOMATCH;
                        for (int i = 0; i < scan_end; i++)
                        begin
                            if (occupied[i] && first_ids[i] == req.first_id &&
                                second_ids[i] == req.second_id)
                            begin
                                release_slot(i);
                                removed = 1;
                                reply.status = STATUS_DONE;
                                last_change = req.now_time;
                                break;
                            end
                        end
                    end
                end
                default:
                begin
                    // Removal by one id checks only that id against the reserved value.
                    key = (req.op == OP_FIRST) ? req.first_id : req.second_id;
                    if (key == reserved)
                        reply.status = STATUS_RESERVED;
                    else
                    begin
                        for (int i = 0; i < scan_end; i++)
                        begin
                            held = (req.op == OP_FIRST) ? first_ids[i] : second_ids[i];
                            if (occupied[i] && held == key)
                            begin
                                release_slot(i);
                                removed++;
                            end
                        end
                        if (removed > 0)
                            last_change = req.now_time;
                        else
                            reply.status = STATUS_NOMATCH;
                    end
                end
            endcase
            reply.removed_count = CNT_W'(removed);
            reply.live_count = CNT_W'(used_count - free_count);
            reply.modified_time = last_change;
            awaited_replies.push_back(reply);
        endfunction

        // Compares one accepted reply with the oldest one waiting.
        function void compare_reply(link_reply_t got);
            link_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                $error("reply with none waiting: status %0d, removed_count %0d",
                       got.status, got.removed_count);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.removed_count !== want.removed_count)
            begin
                $error("removed_count: expected %0d, got %0d",
                       want.removed_count, got.removed_count);
                errors++;
            end
            if (got.live_count !== want.live_count)
            begin
                $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
                errors++;
            end
            if (got.modified_time !== want.modified_time)
            begin
                $error("modified_time: expected %0h, got %0h",
                       want.modified_time, got.modified_time);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction
    endclass

endpackage

>>> verif/tb.sv
// Testbench of the pair table with slot reuse: directed and random requests against a mirror.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptsr_pkg::*;
    import link_table_check_pkg::*;

    // Every request could scan the whole table after the longest gap and stall, with room to spare.
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int POOL_SIZE = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ID_W-1:0]       cfg_data;

    link_table_tracker tracker = new();
    int                idle_pct = 0;
    int                stall_left = 0;
    int unsigned       cycles = 0;
    logic [ID_W-1:0]   first_pool [POOL_SIZE];
    logic [ID_W-1:0]   second_pool [POOL_SIZE];

    pair_table_with_slot_reuse_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit in case the block stops answering.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: stall at random while idling is allowed.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    // Check every accepted result item.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.compare_reply(link_reply_t'(m_tdata));
    end

    // Offers one item, possibly after a short gap, and records it once accepted.
    task automatic send_item(logic [1:0] op, logic [ID_W-1:0] first_id,
                             logic [ID_W-1:0] second_id, logic [ID_W-1:0] now_time);
        link_request_t req;
        int            gap;
        req.op = op;
        req.first_id = first_id;
        req.second_id = second_id;
        req.now_time = now_time;
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(req);
        do
            @(posedge clk);
        while (!s_tready);
        tracker.apply_request(req);
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Writes the reserved id once the block is idle.
    task automatic write_reserved(logic [ID_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.reserved = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A random id that differs from the reserved one.
    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        id = $urandom;
        if (id == tracker.reserved)
            id = ~id;
        return id;
    endfunction

    // Small id pools keep matches frequent and the table short.
    function automatic void refresh_pools();
        foreach (first_pool[i])
        begin
            first_pool[i] = fresh_id();
            second_pool[i] = fresh_id();
        end
    endfunction

    // Mostly pool ids, sometimes the reserved id or a fully random one.
    function automatic logic [ID_W-1:0] pick_id(bit second);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return tracker.reserved;
        if (roll < 12)
            return $urandom;
        return second ? second_pool[$urandom_range(0, POOL_SIZE - 1)]
                      : first_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return OP_ADD;
        if (roll < 65)
            return OP_PAIR;
        if (roll < 82)
            return OP_FIRST;
        return OP_SECOND;
    endfunction

    // Random requests over the current pools; idling changes every 30 items if allowed.
    task automatic random_burst(int count, bit with_idle);
        for (int n = 0; n < count; n++)
        begin
            if (with_idle && n % 30 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            send_item(pick_op(), pick_id(1'b0), pick_id(1'b1), $urandom);
        end
    endtask

    initial
    begin
        logic [ID_W-1:0] bulk_first;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_pct = 25;

        // Directed part with the reserved id at its reset value of zero.
        send_item(OP_ADD, 32'd1, 32'd2, 32'd10);
        send_item(OP_ADD, 32'd1, 32'd3, 32'd0);
        send_item(OP_ADD, 32'd1, 32'd2, $urandom);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'd0, 32'd5, $urandom);
        send_item(OP_ADD, 32'd5, 32'd0, $urandom);
        // Pair removal clears only the lowest of two equal links.
        send_item(OP_PAIR, 32'd1, 32'd2, $urandom);
        send_item(OP_PAIR, 32'd7, 32'd7, $urandom);
        send_item(OP_PAIR, 32'd0, 32'd2, $urandom);
        // Removal by one id ignores the other id field.
        send_item(OP_FIRST, 32'd0, 32'd9, $urandom);
        send_item(OP_FIRST, 32'd1, 32'd0, $urandom);
        send_item(OP_SECOND, 32'd0, 32'hFFFF_FFFF, $urandom);
        send_item(OP_SECOND, 32'd0, 32'hFFFF_FFFF, $urandom);
        send_item(OP_SECOND, 32'd9, 32'd0, $urandom);
        // Adds pop freed slots in reverse order of release.
        send_item(OP_ADD, 32'd4, 32'd4, $urandom);
        send_item(OP_ADD, 32'd4, 32'd5, $urandom);
        send_item(OP_FIRST, 32'd4, 32'd0, $urandom);
        send_item(OP_ADD, 32'd6, 32'd6, $urandom);

        // Freed slots still hold the old reserved id but must never match.
        write_reserved(32'hFFFF_FFFF);
        send_item(OP_FIRST, 32'd0, 32'd1, $urandom);
        send_item(OP_SECOND, 32'd1, 32'd0, $urandom);
        send_item(OP_PAIR, 32'd0, 32'd0, $urandom);
        send_item(OP_ADD, 32'd0, 32'd0, $urandom);
        send_item(OP_PAIR, 32'd0, 32'd0, $urandom);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'd1, $urandom);
        send_item(OP_PAIR, 32'd1, 32'hFFFF_FFFF, $urandom);

        // Random part under three reserved ids.
        write_reserved(32'd0);
        refresh_pools();
        random_burst(150, 1'b1);
        write_reserved($urandom);
        refresh_pools();
        random_burst(150, 1'b1);
        write_reserved(32'hFFFF_FFFF);
        refresh_pools();
        random_burst(150, 1'b1);

        // Load a batch of links with one first id, then hit the reserved check.
        idle_pct = 10;
        write_reserved($urandom);
        bulk_first = fresh_id();
        repeat (30)
            send_item(OP_ADD, bulk_first, fresh_id(), $urandom);
        send_item(OP_ADD, tracker.reserved, fresh_id(), $urandom);
        // Clear the whole batch at once, then refill through the free stack.
        send_item(OP_FIRST, bulk_first, fresh_id(), $urandom);
        refresh_pools();
        repeat (30)
            send_item(OP_ADD, first_pool[$urandom_range(0, POOL_SIZE - 1)],
                      second_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
        send_item(OP_ADD, fresh_id(), fresh_id(), $urandom);

        // Last part: random traffic without idling.
        idle_pct = 0;
        random_burst(40, 1'b0);

        drain();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> pair_table_with_slot_reuse_top.f
+incdir+rtl
rtl/ptsr_pkg.sv
rtl/ptsr_ram.sv
rtl/pair_table_with_slot_reuse_top.sv
rtl/ptsr_checker.sv
verif/link_table_check_pkg.sv
verif/tb.sv
